// ----- hw/rtl/dwes_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwes_pkg
// Shared constants, types and helpers of the degree-weighted edge sampler.
// ----------------------------------------------------------------------------
package dwes_pkg;

  localparam int MAX_EDGES   = 64;
  localparam int DEGREE_BITS = 16;
  localparam int VERTEX_BITS = 16;
  localparam int RANDOM_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_EDGES);
  localparam int CNT_W   = $clog2(MAX_EDGES + 1);
  localparam int DVAL_W  = DEGREE_BITS + 1;
  localparam int PFX_W   = DVAL_W + CNT_W + IDX_W;
  localparam int EP_W    = 2 * VERTEX_BITS;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_DRAW  = 2'd2;

  localparam logic [1:0] RULE_MAX  = 2'd0;
  localparam logic [1:0] RULE_MIN  = 2'd1;
  localparam logic [1:0] RULE_SUM  = 2'd2;
  localparam logic [1:0] RULE_DIFF = 2'd3;

  localparam logic REG_DEGREE_RULE     = 1'b0;
  localparam logic REG_REQUESTED_EDGES = 1'b1;

  // edge store write request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [EP_W-1:0]   endpoints;
    logic [DVAL_W-1:0] dval;
  } edge_wr_t;

  function automatic logic [DVAL_W-1:0] combine(
    input logic [1:0] rule,
    input logic [DEGREE_BITS-1:0] a,
    input logic [DEGREE_BITS-1:0] b
  );
    logic [DVAL_W-1:0] ea;
    logic [DVAL_W-1:0] eb;
    ea = {1'b0, a};
    eb = {1'b0, b};
    case (rule)
      RULE_MAX: combine = (ea > eb) ? ea : eb;
      RULE_MIN: combine = (ea < eb) ? ea : eb;
      RULE_SUM: combine = ea + eb;
      default:  combine = (ea > eb) ? ea - eb : eb - ea;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dwes_edge_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwes_edge_mem
// Edge store: endpoints and combined degree value, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module dwes_edge_mem (
  input  wire logic                        clk,
  input  wire dwes_pkg::edge_wr_t          wr,
  input  wire logic [dwes_pkg::IDX_W-1:0]  rd_addr,
  output logic      [dwes_pkg::EP_W-1:0]   rd_endpoints,
  output logic      [dwes_pkg::DVAL_W-1:0] rd_dval
);

  logic [dwes_pkg::EP_W-1:0]   ep_mem [dwes_pkg::MAX_EDGES];
  logic [dwes_pkg::DVAL_W-1:0] dv_mem [dwes_pkg::MAX_EDGES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ep_mem[wr.addr] <= wr.endpoints;
      dv_mem[wr.addr] <= wr.dval;
    end
    rd_endpoints <= ep_mem[rd_addr];
    rd_dval      <= dv_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dwes_prefix_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwes_prefix_mem
// Prefix-sum store, one write and one registered read port.
// ----------------------------------------------------------------------------
module dwes_prefix_mem (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [dwes_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [dwes_pkg::PFX_W-1:0] wr_data,
  input  wire logic [dwes_pkg::IDX_W-1:0] rd_addr,
  output logic      [dwes_pkg::PFX_W-1:0] rd_data
);

  logic [dwes_pkg::PFX_W-1:0] mem [dwes_pkg::MAX_EDGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/degree_weighted_edge_sampler_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// degree_weighted_edge_sampler_core
// Roulette-wheel selection of distinct edges weighted by endpoint degrees.
// ----------------------------------------------------------------------------
// Usage: raise start with kind and the fields; the request is taken when busy
// is low. kind 0 clears the run, 1 loads an edge, 2 draws with random_fraction.
// Configuration (degree_rule, requested_edges) is to be written via
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
// Results appear for one cycle with result_valid high; the receiver cannot
// stall. last marks the final result of a request, done_res the completion
// of the requested selection.
// Sequence: clear and load complete without leaving idle. A draw after a load
// first rebuilds the prefix sums, one edge per cycle (one edge-memory read each),
// forms the scaled target in ST_MUL, scans the prefix store one entry per cycle
// and reads the picked edge (ST_PICK, ST_EMIT). The result shows in the same
// cycle in which busy falls; a pick of an edge chosen before emits nothing. A
// covering draw emits N results, one per cycle, after a read state (ST_ALLRD).
// The scale of r*total uses one 16x30 multiply, registered.
// Reset clears counts, flags and marks; stores need no clearing.
// ----------------------------------------------------------------------------
module degree_weighted_edge_sampler_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       kind,
  input  wire logic [dwes_pkg::VERTEX_BITS-1:0] vertex_a,
  input  wire logic [dwes_pkg::VERTEX_BITS-1:0] vertex_b,
  input  wire logic [dwes_pkg::DEGREE_BITS-1:0] degree_a,
  input  wire logic [dwes_pkg::DEGREE_BITS-1:0] degree_b,
  input  wire logic [dwes_pkg::RANDOM_BITS-1:0] random_fraction,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [6:0]                       cfg_data,
  output logic                                  result_valid,
  output logic      [15:0]                      chosen_vertex_a,
  output logic      [15:0]                      chosen_vertex_b,
  output logic      [5:0]                       edge_index,
  output logic                                  last,
  output logic                                  done_res
);

  localparam int IW = dwes_pkg::IDX_W;
  localparam int CW = dwes_pkg::CNT_W;
  localparam int PW = dwes_pkg::PFX_W;
  localparam int RB = dwes_pkg::RANDOM_BITS;
  localparam int VB = dwes_pkg::VERTEX_BITS;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_BUILD = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_PICK  = 8'b0001_0000,
    ST_EMIT  = 8'b0010_0000,
    ST_ALL   = 8'b0100_0000,
    ST_ALLRD = 8'b1000_0000
  } state_t;

  state_t state;

  logic [1:0]    degree_rule;
  logic [6:0]    requested_edges;
  logic [CW-1:0] loaded_count;
  logic [CW-1:0] selected_count;
  logic          prepared_flag;
  logic          finished_flag;
  logic [dwes_pkg::MAX_EDGES-1:0] chosen_marks;
  logic [PW-1:0] total_weight;
  logic [PW-1:0] run_sum;
  logic [CW-1:0] ptr;
  logic          rd_pending;
  logic [IW-1:0] pick;
  logic [RB-1:0] r_hold;
  logic [PW-1:0] target;
  logic          pick_fin;

  dwes_pkg::edge_wr_t          ewr;
  logic [IW-1:0]               e_rd_addr;
  logic [dwes_pkg::EP_W-1:0]   e_rd_ep;
  logic [dwes_pkg::DVAL_W-1:0] e_rd_dv;
  logic                        p_we;
  logic [IW-1:0]               p_wr_addr;
  logic [IW-1:0]               p_rd_addr;
  logic [PW-1:0]               p_rd_data;

  logic [RB+PW-1:0] product;
  logic [PW-1:0]    weight;

  logic take;
  assign take = start && !busy;
  assign busy = (state != ST_IDLE);

  assign ewr.en        = take && (kind == dwes_pkg::KIND_LOAD) &&
                         (loaded_count < CW'(dwes_pkg::MAX_EDGES));
  assign ewr.addr      = loaded_count[IW-1:0];
  assign ewr.endpoints = {vertex_a, vertex_b};
  assign ewr.dval      = dwes_pkg::combine(degree_rule, degree_a, degree_b);

  dwes_edge_mem u_edge_mem (
    .clk          (clk),
    .wr           (ewr),
    .rd_addr      (e_rd_addr),
    .rd_endpoints (e_rd_ep),
    .rd_dval      (e_rd_dv)
  );

  dwes_prefix_mem u_prefix_mem (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (p_wr_addr),
    .wr_data (run_sum),
    .rd_addr (p_rd_addr),
    .rd_data (p_rd_data)
  );

  assign weight = PW'(loaded_count) * PW'(e_rd_dv) + PW'(1);
  // build: read at ptr, data of ptr-1 arrives while rd_pending
  assign p_we      = (state == ST_BUILD) && rd_pending;
  assign p_wr_addr = IW'(ptr - CW'(1));

  always_comb begin
    e_rd_addr = ptr[IW-1:0];
    if (state == ST_PICK) begin
      e_rd_addr = pick;
    end
  end
  assign p_rd_addr = ptr[IW-1:0];

  always_ff @(posedge clk) begin
    product <= r_hold * total_weight;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      degree_rule     <= dwes_pkg::RULE_MAX;
      requested_edges <= 7'd1;
      loaded_count    <= '0;
      selected_count  <= '0;
      prepared_flag   <= 1'b0;
      finished_flag   <= 1'b0;
      chosen_marks    <= '0;
      result_valid    <= 1'b0;
      rd_pending      <= 1'b0;
      ptr             <= '0;
    end else begin
      result_valid <= (state == ST_EMIT) || (state == ST_ALL);
      if (cfg_we) begin
        if (cfg_index == dwes_pkg::REG_DEGREE_RULE) begin
          degree_rule <= cfg_data[1:0];
        end else begin
          requested_edges <= cfg_data;
        end
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            r_hold <= random_fraction;
            ptr    <= '0;
            rd_pending <= 1'b0;
            case (kind)
              dwes_pkg::KIND_CLEAR: begin
                loaded_count   <= '0;
                selected_count <= '0;
                prepared_flag  <= 1'b0;
                finished_flag  <= 1'b0;
                chosen_marks   <= '0;
              end
              dwes_pkg::KIND_LOAD: begin
                if (ewr.en) begin
                  loaded_count  <= loaded_count + CW'(1);
                  prepared_flag <= 1'b0;
                end
              end
              dwes_pkg::KIND_DRAW: begin
                if (loaded_count != '0 && !finished_flag) begin
                  if (requested_edges >= 7'(loaded_count)) begin
                    state <= ST_ALLRD;
                  end else if (7'(selected_count) >= requested_edges) begin
                    finished_flag <= 1'b1;
                  end else if (!prepared_flag) begin
                    run_sum <= '0;
                    state   <= ST_BUILD;
                  end else begin
                    state <= ST_MUL;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_BUILD: begin
          if (rd_pending) begin
            run_sum <= run_sum + weight;
          end
          if (ptr == loaded_count) begin
            if (rd_pending) begin
              total_weight <= run_sum + weight;
            end
            rd_pending <= 1'b0;
            prepared_flag <= 1'b1;
            ptr   <= '0;
            state <= ST_MUL;
          end else begin
            rd_pending <= 1'b1;
            ptr        <= ptr + CW'(1);
          end
        end
        ST_MUL: begin
          // product registered this cycle
          state <= ST_SCAN;
          pick  <= '0;
          ptr   <= CW'(1);
          rd_pending <= 1'b0;
        end
        ST_SCAN: begin
          if (!rd_pending) begin
            target <= PW'(product >> RB);
          end
          if (rd_pending && p_rd_data <= target) begin
            pick <= IW'(ptr - CW'(1));
          end
          if (ptr == loaded_count) begin
            if (rd_pending || ptr == CW'(1)) begin
              state <= ST_PICK;
            end
            rd_pending <= 1'b0;
            ptr <= ptr + CW'(1);
          end else begin
            rd_pending <= 1'b1;
            ptr <= ptr + CW'(1);
          end
          if (ptr > loaded_count) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (chosen_marks[pick]) begin
            state <= ST_IDLE;
          end else begin
            chosen_marks[pick] <= 1'b1;
            selected_count <= selected_count + CW'(1);
            pick_fin <= (7'(selected_count + CW'(1)) >= requested_edges);
            if (7'(selected_count + CW'(1)) >= requested_edges) begin
              finished_flag <= 1'b1;
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          chosen_vertex_a <= 16'(e_rd_ep[2*VB-1:VB]);
          chosen_vertex_b <= 16'(e_rd_ep[VB-1:0]);
          edge_index      <= 6'(pick);
          last            <= 1'b1;
          done_res        <= pick_fin;
          state           <= ST_IDLE;
        end
        ST_ALLRD: begin
          ptr   <= CW'(1);
          pick  <= '0;
          state <= ST_ALL;
        end
        ST_ALL: begin
          chosen_vertex_a <= 16'(e_rd_ep[2*VB-1:VB]);
          chosen_vertex_b <= 16'(e_rd_ep[VB-1:0]);
          edge_index      <= 6'(pick);
          last            <= (ptr == loaded_count);
          done_res        <= (ptr == loaded_count);
          chosen_marks[pick] <= 1'b1;
          pick <= ptr[IW-1:0];
          ptr  <= ptr + CW'(1);
          if (ptr == loaded_count) begin
            selected_count <= loaded_count;
            finished_flag  <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // in build and all-edge states the read address is ptr; ST_ALL uses pick
  // address one ahead through ptr as well

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CW'(dwes_pkg::MAX_EDGES))
    else $error("loaded count overflow");

  a_sel_bound: assert property (@(posedge clk) disable iff (rst)
    selected_count <= loaded_count)
    else $error("selected more than loaded");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && done_res |-> last)
    else $error("done without last");

  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy || $past(state) == ST_ALL)
    else $error("result outside a request");

endmodule
`default_nettype wire

// ----- dv/tb_degree_weighted_edge_sampler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_degree_weighted_edge_sampler_core
// Loads edge lists under every degree rule and varied request counts, draws with
// random fractions and checks each emitted edge against a cycle-free model
// of the weighted roulette selection held in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_degree_weighted_edge_sampler_core;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [15:0] va;
    logic [15:0] vb;
    logic [5:0]  idx;
    logic        lst;
    logic        dn;
  } edge_pick_t;

  class edge_pick_scoreboard;
    logic [31:0] endpoints[dwes_pkg::MAX_EDGES];
    logic [16:0] dval[dwes_pkg::MAX_EDGES];
    longint      pfx[dwes_pkg::MAX_EDGES];
    longint      total;
    bit          marks[dwes_pkg::MAX_EDGES];
    int          n_loaded;
    int          n_selected;
    bit          prepared;
    bit          finished;
    logic [1:0]  rule;
    int          requested;
    edge_pick_t  expected_picks[$];
    int          errors;

    function new();
      clear_run();
      rule = dwes_pkg::RULE_MAX;
      requested = 1;
      errors = 0;
    endfunction

    function void clear_run();
      foreach (marks[i]) marks[i] = 0;
      n_loaded = 0;
      n_selected = 0;
      prepared = 0;
      finished = 0;
      total = 0;
    endfunction

    function void set_reg(logic index, logic [6:0] data);
      if (index == dwes_pkg::REG_DEGREE_RULE) rule = data[1:0];
      else requested = data;
    endfunction

    function void push_pick(int j, bit lst, bit dn);
      edge_pick_t p;
      p.va = endpoints[j][31:16];
      p.vb = endpoints[j][15:0];
      p.idx = j[5:0];
      p.lst = lst;
      p.dn = dn;
      expected_picks = {expected_picks, p};
    endfunction

    function void note_request(logic [1:0] k, logic [15:0] va, logic [15:0] vb,
                               logic [15:0] da, logic [15:0] db, logic [15:0] r);
      logic [16:0] a;
      logic [16:0] b;
      longint      run;
      longint      t;
      int          pick;
      case (k)
        dwes_pkg::KIND_CLEAR: clear_run();
        dwes_pkg::KIND_LOAD: begin
          if (n_loaded < dwes_pkg::MAX_EDGES) begin
            a = {1'b0, da};
            b = {1'b0, db};
            endpoints[n_loaded] = {va, vb};
            case (rule)
              dwes_pkg::RULE_MAX: dval[n_loaded] = (a > b) ? a : b;
              dwes_pkg::RULE_MIN: dval[n_loaded] = (a < b) ? a : b;
              dwes_pkg::RULE_SUM: dval[n_loaded] = a + b;
              default:  dval[n_loaded] = (a > b) ? a - b : b - a;
            endcase
            n_loaded++;
            prepared = 0;
          end
        end
        dwes_pkg::KIND_DRAW: begin
          if (n_loaded != 0 && !finished) begin
            if (requested >= n_loaded) begin
              for (int j = 0; j < n_loaded; j++) begin
                marks[j] = 1;
                push_pick(j, j + 1 == n_loaded, j + 1 == n_loaded);
              end
              n_selected = n_loaded;
              finished = 1;
            end else if (n_selected >= requested) begin
              finished = 1;
            end else begin
              if (!prepared) begin
                run = 0;
                for (int j = 0; j < n_loaded; j++) begin
                  pfx[j] = run;
                  run += longint'(n_loaded) * longint'(dval[j]) + 1;
                end
                total = run;
                prepared = 1;
              end
              t = (longint'(r) * total) >>> dwes_pkg::RANDOM_BITS;
              pick = 0;
              for (int j = 1; j < n_loaded; j++) if (pfx[j] <= t) pick = j;
              if (!marks[pick]) begin
                marks[pick] = 1;
                n_selected++;
                if (n_selected >= requested) finished = 1;
                push_pick(pick, 1, finished);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(edge_pick_t got);
      edge_pick_t e;
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected result va=%h vb=%h idx=%0d", $time,
                 got.va, got.vb, got.idx);
        errors++;
        return;
      end
      e = expected_picks.pop_front();
      if (got.va !== e.va) begin
        $display("%0t: chosen_vertex_a expected %h actual %h", $time, e.va, got.va);
        errors++;
      end
      if (got.vb !== e.vb) begin
        $display("%0t: chosen_vertex_b expected %h actual %h", $time, e.vb, got.vb);
        errors++;
      end
      if (got.idx !== e.idx) begin
        $display("%0t: edge_index expected %0d actual %0d", $time, e.idx, got.idx);
        errors++;
      end
      if (got.lst !== e.lst) begin
        $display("%0t: last expected %b actual %b", $time, e.lst, got.lst);
        errors++;
      end
      if (got.dn !== e.dn) begin
        $display("%0t: done_res expected %b actual %b", $time, e.dn, got.dn);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  kind = dwes_pkg::KIND_CLEAR;
  logic [15:0] vertex_a = '0;
  logic [15:0] vertex_b = '0;
  logic [15:0] degree_a = '0;
  logic [15:0] degree_b = '0;
  logic [15:0] random_fraction = '0;
  logic        cfg_we = 0;
  logic        cfg_index = dwes_pkg::REG_DEGREE_RULE;
  logic [6:0]  cfg_data = '0;
  logic        result_valid;
  logic [15:0] chosen_vertex_a;
  logic [15:0] chosen_vertex_b;
  logic [5:0]  edge_index;
  logic        last;
  logic        done_res;

  edge_pick_scoreboard sb = new();
  int accepts = 0;
  int cycles = 0;
  int sent = 0;
  int burst_left = 0;

  degree_weighted_edge_sampler_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .degree_a(degree_a),
    .degree_b(degree_b), .random_fraction(random_fraction),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .chosen_vertex_a(chosen_vertex_a),
    .chosen_vertex_b(chosen_vertex_b), .edge_index(edge_index),
    .last(last), .done_res(done_res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    edge_pick_t got;
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst) begin
      if (result_valid) begin
        got.va = chosen_vertex_a;
        got.vb = chosen_vertex_b;
        got.idx = edge_index;
        got.lst = last;
        got.dn = done_res;
        sb.check_result(got);
      end
      if (cfg_we) sb.set_reg(cfg_index, cfg_data);
      if (start && !busy) begin
        sb.note_request(kind, vertex_a, vertex_b, degree_a, degree_b, random_fraction);
        accepts <= accepts + 1;
      end
    end
  end

  function automatic logic [15:0] rnd16();
    if ($urandom_range(0, 3) == 0) return {16{1'($urandom_range(0, 1))}};
    return 16'($urandom);
  endfunction

  task automatic send(logic [1:0] k, logic [15:0] va, logic [15:0] vb,
                      logic [15:0] da, logic [15:0] db, logic [15:0] r);
    int seen;
    if (burst_left == 0) begin
      start = 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    kind = k;
    vertex_a = va;
    vertex_b = vb;
    degree_a = da;
    degree_b = db;
    random_fraction = r;
    start = 1;
    seen = accepts;
    do @(negedge clk); while (accepts == seen);
    start = 0;
    if (k != KIND_UNUSED) sent++;
  endtask

  task automatic load_edge();
    send(dwes_pkg::KIND_LOAD, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic draw();
    send(dwes_pkg::KIND_DRAW, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic write_reg(logic index, logic [6:0] data);
    wait (sb.expected_picks.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_index = index;
    cfg_data = data;
    cfg_we = 1;
    @(negedge clk);
    cfg_we = 0;
  endtask

  initial begin
    int n;
    int req;
    repeat (2) @(negedge clk);
    rst = 0;

    // directed: empty draw, extremes, covering run, unused kind
    send(dwes_pkg::KIND_DRAW, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff);
    send(dwes_pkg::KIND_LOAD, 16'hffff, 16'h0000, 16'hffff, 16'hffff, 16'h0);
    send(dwes_pkg::KIND_LOAD, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0);
    send(dwes_pkg::KIND_LOAD, 16'h1234, 16'habcd, 16'hffff, 16'h0000, 16'h0);
    send(dwes_pkg::KIND_DRAW, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0000);
    send(dwes_pkg::KIND_DRAW, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff);
    send(dwes_pkg::KIND_DRAW, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8000);
    send(KIND_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    write_reg(dwes_pkg::REG_REQUESTED_EDGES, 7'd64);
    send(dwes_pkg::KIND_DRAW, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send(dwes_pkg::KIND_DRAW, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send(dwes_pkg::KIND_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    repeat (65) load_edge();
    draw();
    write_reg(dwes_pkg::REG_REQUESTED_EDGES, 7'd0);
    send(dwes_pkg::KIND_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    load_edge();
    load_edge();
    draw();
    write_reg(dwes_pkg::REG_REQUESTED_EDGES, 7'd63);
    write_reg(dwes_pkg::REG_DEGREE_RULE, 7'(dwes_pkg::RULE_DIFF));

    // random phases
    while (sent < 480) begin
      write_reg(dwes_pkg::REG_DEGREE_RULE, 7'($urandom_range(0, 3)));
      n = ($urandom_range(0, 9) == 0) ? dwes_pkg::MAX_EDGES : $urandom_range(1, 12);
      case ($urandom_range(0, 5))
        0: req = 0;
        1: req = n;
        2: req = 64;
        default: req = $urandom_range(1, n);
      endcase
      write_reg(dwes_pkg::REG_REQUESTED_EDGES, 7'(req));
      send(dwes_pkg::KIND_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
      for (int i = 0; i < n; i++) begin
        load_edge();
        if ($urandom_range(0, 15) == 0) draw();
      end
      for (int d = 0; d < 30 && !sb.finished; d++) begin
        draw();
        if ($urandom_range(0, 19) == 0) load_edge();
        if ($urandom_range(0, 29) == 0)
          send(KIND_UNUSED, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
      end
      draw();
    end

    wait (sb.expected_picks.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_picks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dwes_pkg.sv
hw/rtl/dwes_edge_mem.sv
hw/rtl/dwes_prefix_mem.sv
hw/rtl/degree_weighted_edge_sampler_core.sv
dv/tb_degree_weighted_edge_sampler_core.sv
